FILE: hw/rtl/seci_pkg.sv
// shared types, constants and codes for the segment energy calibration unit
package seci_pkg;

   localparam int NUM_SEGMENTS_DEF = 32;
   localparam int MAX_POINTS_DEF   = 16;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_CONVERT = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_BAD_SEGMENT   = 3'd1,
      ST_FULL          = 3'd2,
      ST_EMPTY         = 3'd3,
      ST_ZERO_INTERVAL = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [7:0]         segment;
      logic signed [23:0] height;
      logic signed [31:0] point_energy;
   } req_type;

   typedef struct packed {
      logic signed [31:0] energy;
      status_type         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LAST_RD,
      S_LAST_CHK,
      S_SEARCH_RD,
      S_SEARCH_CHK,
      S_PAIR_RD0,
      S_PAIR_RD1,
      S_PAIR_CHK,
      S_MUL,
      S_DIV,
      S_FINISH,
      S_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       append;
      logic       clear;
      logic       rd_last;
      logic       rd_k;
      logic       inc_k;
      logic       set_k_last;
      logic       rd_k_prev;
      logic       latch_hi;
      logic       latch_lo;
      logic       div_start;
      logic       finish;
      logic       respond;
      status_type status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       seg_bad;
      logic       full;
      logic       empty;
      logic       q_below_last;
      logic       search_stop;
      logic       k_zero;
      logic       dh_zero;
      logic       div_done;
      opcode_type opcode;
   } sts_type;

endpackage

FILE: hw/rtl/seci_ctrl.sv
// sequencing state machine for append, clear and convert transactions
module seci_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  seci_pkg::sts_type sts,
   output seci_pkg::cmd_type cmd
);

   seci_pkg::state_type state_ff, state_in;
   seci_pkg::status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= seci_pkg::S_IDLE;
         status_ff <= seci_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      case (state_ff)
         seci_pkg::S_IDLE: begin
            if (start) state_in = seci_pkg::S_DECODE;
         end
         seci_pkg::S_DECODE: begin
            status_in = seci_pkg::ST_OK;
            state_in  = seci_pkg::S_RESPOND;
            case (sts.opcode)
               seci_pkg::OP_APPEND: begin
                  if (sts.seg_bad) status_in = seci_pkg::ST_BAD_SEGMENT;
                  else if (sts.full) status_in = seci_pkg::ST_FULL;
               end
               seci_pkg::OP_CONVERT: begin
                  if (sts.seg_bad) status_in = seci_pkg::ST_BAD_SEGMENT;
                  else if (sts.empty) status_in = seci_pkg::ST_EMPTY;
                  else state_in = seci_pkg::S_LAST_RD;
               end
               default: ;
            endcase
         end
         seci_pkg::S_LAST_RD:  state_in = seci_pkg::S_LAST_CHK;
         seci_pkg::S_LAST_CHK: begin
            if (sts.q_below_last) state_in = seci_pkg::S_SEARCH_RD;
            else state_in = seci_pkg::S_PAIR_RD0;
         end
         seci_pkg::S_SEARCH_RD:  state_in = seci_pkg::S_SEARCH_CHK;
         seci_pkg::S_SEARCH_CHK: begin
            if (sts.search_stop) state_in = seci_pkg::S_PAIR_RD0;
            else state_in = seci_pkg::S_SEARCH_RD;
         end
         seci_pkg::S_PAIR_RD0: begin
            if (sts.k_zero) state_in = seci_pkg::S_RESPOND;
            else state_in = seci_pkg::S_PAIR_RD1;
         end
         seci_pkg::S_PAIR_RD1: state_in = seci_pkg::S_PAIR_CHK;
         seci_pkg::S_PAIR_CHK: begin
            if (sts.dh_zero) begin
               status_in = seci_pkg::ST_ZERO_INTERVAL;
               state_in  = seci_pkg::S_RESPOND;
            end else begin
               state_in = seci_pkg::S_MUL;
            end
         end
         seci_pkg::S_MUL: state_in = seci_pkg::S_DIV;
         seci_pkg::S_DIV: begin
            if (sts.div_done) state_in = seci_pkg::S_FINISH;
         end
         seci_pkg::S_FINISH:  state_in = seci_pkg::S_RESPOND;
         seci_pkg::S_RESPOND: state_in = seci_pkg::S_IDLE;
         default: state_in = seci_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.status     = status_ff;
      busy           = (state_ff != seci_pkg::S_IDLE);
      case (state_ff)
         seci_pkg::S_IDLE: cmd.load_req = start;
         seci_pkg::S_DECODE: begin
            cmd.append = (sts.opcode == seci_pkg::OP_APPEND) && !sts.seg_bad && !sts.full;
            cmd.clear  = (sts.opcode == seci_pkg::OP_CLEAR);
         end
         seci_pkg::S_LAST_RD:  cmd.rd_last = 1'b1;
         seci_pkg::S_LAST_CHK: cmd.set_k_last = !sts.q_below_last;
         seci_pkg::S_SEARCH_RD: cmd.rd_k = 1'b1;
         seci_pkg::S_SEARCH_CHK: cmd.inc_k = !sts.search_stop;
         seci_pkg::S_PAIR_RD0: begin
            cmd.rd_k     = !sts.k_zero;
            cmd.latch_lo = 1'b0;
         end
         seci_pkg::S_PAIR_RD1: begin
            cmd.latch_hi  = 1'b1;
            cmd.rd_k_prev = 1'b1;
         end
         seci_pkg::S_PAIR_CHK: cmd.latch_lo = 1'b1;
         // product goes straight into the divider
         seci_pkg::S_MUL:      cmd.div_start = 1'b1;
         seci_pkg::S_FINISH:   cmd.finish = 1'b1;
         seci_pkg::S_RESPOND:  cmd.respond = 1'b1;
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/seci_div.sv
// restoring signed divider, one quotient bit per cycle, truncates toward zero
module seci_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] dividend,
   input  logic signed [24:0] divisor,
   output logic               done,
   output logic signed [63:0] quotient
);

   logic [6:0]  count_ff, count_in;
   logic        run_ff, run_in;
   logic [63:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [24:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [25:0] trial;

   assign trial = {rem_ff, quo_ff[63]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      run_in   = run_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = 7'd0;
         quo_in   = dividend[63] ? 64'(-dividend) : dividend;
         rem_in   = '0;
         den_in   = divisor[24] ? 25'(-divisor) : divisor;
         neg_in   = dividend[63] ^ divisor[24];
      end else if (run_ff) begin
         if (!trial[25]) rem_in = trial[24:0];
         else rem_in = {rem_ff[23:0], quo_ff[63]};
         quo_in   = {quo_ff[62:0], !trial[25]};
         count_in = count_ff + 7'd1;
         if (count_ff == 7'd63) run_in = 1'b0;
      end
   end

   assign done     = run_ff && (count_ff == 7'd63);
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

FILE: hw/rtl/seci_dp.sv
// datapath: point counts, height and energy memories, multiply and divide
module seci_dp #(
   parameter int NUM_SEGMENTS = seci_pkg::NUM_SEGMENTS_DEF,
   parameter int MAX_POINTS   = seci_pkg::MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  seci_pkg::req_type req,
   input  seci_pkg::cmd_type cmd,
   output seci_pkg::sts_type sts,
   output logic              rsp_valid,
   output seci_pkg::rsp_type rsp
);

   localparam int SW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int PW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DEPTH = NUM_SEGMENTS * MAX_POINTS;
   localparam int AW = $clog2(DEPTH);

   seci_pkg::req_type req_ff;
   logic [CW-1:0] count_ff [NUM_SEGMENTS];
   logic signed [23:0] hmem [DEPTH];
   logic signed [31:0] emem [DEPTH];
   logic signed [23:0] hrd_ff;
   logic signed [31:0] erd_ff;
   logic [PW-1:0] k_ff, k_in;
   logic signed [23:0] hlast_ff, h1_ff, h0_ff;
   logic signed [31:0] e1_ff, e0_ff;
   logic signed [31:0] energy_ff;
   logic rsp_valid_ff;
   logic [SW-1:0] seg;
   logic [CW-1:0] cnt;
   logic [PW-1:0] last;
   logic [PW-1:0] rd_idx;
   logic [AW-1:0] rd_addr, wr_addr;
   logic signed [24:0] dh;
   logic signed [32:0] de;
   logic signed [24:0] dq;
   logic signed [57:0] prod;
   logic div_done;
   logic signed [63:0] quo;
   logic signed [64:0] sum;

   assign seg  = SW'(req_ff.segment);
   assign cnt  = count_ff[seg];
   assign last = PW'(cnt - CW'(1));

   always_comb begin
      rd_idx = '0;
      if (cmd.rd_last) rd_idx = last;
      else if (cmd.rd_k_prev) rd_idx = k_ff - PW'(1);
      else if (cmd.rd_k) rd_idx = k_ff;
   end
   assign rd_addr = AW'(seg) * AW'(MAX_POINTS) + AW'(rd_idx);
   assign wr_addr = AW'(seg) * AW'(MAX_POINTS) + AW'(cnt);

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         hmem[wr_addr] <= req_ff.height;
         emem[wr_addr] <= req_ff.point_energy;
      end
      hrd_ff <= hmem[rd_addr];
      erd_ff <= emem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEGMENTS; i++) count_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            for (int i = 0; i < NUM_SEGMENTS; i++) count_ff[i] <= '0;
         end else if (cmd.append) begin
            count_ff[seg] <= cnt + CW'(1);
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.load_req) k_in = '0;
      else if (cmd.set_k_last) k_in = last;
      else if (cmd.inc_k) k_in = k_ff + PW'(1);
   end

   assign dh = 25'(h1_ff) - 25'(h0_ff);
   assign de = 33'(e1_ff) - 33'(e0_ff);
   assign dq = 25'(req_ff.height) - 25'(h0_ff);
   assign prod = de * dq;
   assign sum = 65'(e0_ff) + 65'(quo);

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.load_req) begin
         req_ff    <= req;
         energy_ff <= '0;
      end
      if (cmd.rd_last) hlast_ff <= hmem[rd_addr];
      if (cmd.latch_hi) begin
         h1_ff <= hrd_ff;
         e1_ff <= erd_ff;
      end
      if (cmd.latch_lo) begin
         h0_ff <= hrd_ff;
         e0_ff <= erd_ff;
      end
      if (cmd.finish) begin
         if (sum > 65'sd2147483647) energy_ff <= 32'sh7fffffff;
         else if (sum < -65'sd2147483648) energy_ff <= 32'sh80000000;
         else energy_ff <= sum[31:0];
      end
   end

   seci_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (64'(prod)),
      .divisor  (dh),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      sts.seg_bad      = 32'(req_ff.segment) >= NUM_SEGMENTS;
      sts.full         = 32'(cnt) >= MAX_POINTS;
      sts.empty        = (cnt == '0);
      sts.q_below_last = req_ff.height < hlast_ff;
      sts.search_stop  = (k_ff == last) || !(req_ff.height > hrd_ff);
      sts.k_zero       = (k_ff == '0);
      // lower point is still on the read register while the pair is checked
      sts.dh_zero      = (h1_ff == hrd_ff);
      sts.div_done     = div_done;
      sts.opcode       = req_ff.opcode;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp.energy = (cmd.status == seci_pkg::ST_OK) ? energy_ff : '0;
   assign rsp.status = cmd.status;

endmodule

FILE: hw/rtl/segment_energy_calibration_interp_unit.sv
// top level of the segment energy calibration interpolation unit
//
// channel  ports                      direction  handshake
// request  start, busy, req_payload   in         taken when start && !busy
// response rsp_valid, rsp_payload     out        one-cycle strobe, no stall
//
// append, clear, full, bad segment, empty: DECODE, then RESPOND, which
// registers the strobe; convert can add the last-point check, the search, the
// pair reads, MUL, the serial divider and FINISH; the divider takes longest
// synchronous reset clears all point counts; the memories are not cleared
// the response cannot be held off; busy drops in the strobe cycle, so the next
// start is taken at the edge that ends it
module segment_energy_calibration_interp_unit #(
   parameter int NUM_SEGMENTS = seci_pkg::NUM_SEGMENTS_DEF,
   parameter int MAX_POINTS   = seci_pkg::MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  seci_pkg::req_type req_payload,
   output logic              rsp_valid,
   output seci_pkg::rsp_type rsp_payload
);

   seci_pkg::cmd_type cmd;
   seci_pkg::sts_type sts;

   seci_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   seci_dp #(
      .NUM_SEGMENTS (NUM_SEGMENTS),
      .MAX_POINTS   (MAX_POINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_payload),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response strobe while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != seci_pkg::ST_OK) |-> rsp_payload.energy == '0)
      else $error("error response carries energy");

endmodule

FILE: dv/tb.sv
// testbench for the segment energy calibration interpolation unit
module tb;

   localparam int NSEG = seci_pkg::NUM_SEGMENTS_DEF;
   localparam int NPTS = seci_pkg::MAX_POINTS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   seci_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   seci_pkg::rsp_type rsp_payload;

   segment_energy_calibration_interp_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   int unsigned           cal_count [NSEG];
   logic signed [23:0]    cal_height [NSEG][NPTS];
   logic signed [31:0]    cal_energy [NSEG][NPTS];
   seci_pkg::rsp_type     energy_expected [$];
   int                    mismatches = 0;
   int                    idle_cycles = 0;
   bit                    timed_out = 0;

   function automatic seci_pkg::rsp_type interpolate(int unsigned seg,
                                                     logic signed [23:0] q);
      seci_pkg::rsp_type r;
      int unsigned n, k;
      longint h0, dh, de, num, e;
      r = '0;
      r.status = seci_pkg::ST_OK;
      n = cal_count[seg];
      k = 0;
      if (n == 0) begin
         r.status = seci_pkg::ST_EMPTY;
         return r;
      end
      if (q < cal_height[seg][n-1]) begin
         while (k < n - 1 && q > cal_height[seg][k]) k++;
      end else begin
         k = n - 1;
      end
      if (k == 0) return r;
      h0 = cal_height[seg][k-1];
      dh = longint'(cal_height[seg][k]) - h0;
      if (dh == 0) begin
         r.status = seci_pkg::ST_ZERO_INTERVAL;
         return r;
      end
      de = longint'(cal_energy[seg][k]) - longint'(cal_energy[seg][k-1]);
      num = de * (longint'(q) - h0);
      e = longint'(cal_energy[seg][k-1]) + num / dh;
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      if (e < -64'sd2147483648) e = -64'sd2147483648;
      r.energy = e[31:0];
      return r;
   endfunction

   function automatic seci_pkg::rsp_type apply_request(seci_pkg::req_type t);
      seci_pkg::rsp_type r;
      r = '0;
      r.status = seci_pkg::ST_OK;
      case (t.opcode)
         seci_pkg::OP_APPEND: begin
            if (t.segment >= NSEG) r.status = seci_pkg::ST_BAD_SEGMENT;
            else if (cal_count[t.segment] >= NPTS) r.status = seci_pkg::ST_FULL;
            else begin
               cal_height[t.segment][cal_count[t.segment]] = t.height;
               cal_energy[t.segment][cal_count[t.segment]] = t.point_energy;
               cal_count[t.segment]++;
            end
         end
         seci_pkg::OP_CONVERT: begin
            if (t.segment >= NSEG) r.status = seci_pkg::ST_BAD_SEGMENT;
            else r = interpolate(32'(t.segment), t.height);
         end
         seci_pkg::OP_CLEAR: foreach (cal_count[i]) cal_count[i] = 0;
         default: ;
      endcase
      return r;
   endfunction

   // burst pacing of the sender
   int burst_left = 0;

   task automatic send_request(seci_pkg::req_type t);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      energy_expected = {energy_expected, apply_request(t)};
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (energy_expected.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            seci_pkg::rsp_type e;
            idle_cycles <= 0;
            if (energy_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %h", rsp_payload);
            end else begin
               e = energy_expected.pop_front();
               if (e.energy !== rsp_payload.energy || e.status !== rsp_payload.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected energy %0d status %0d, %s %0d status %0d",
                              e.energy, e.status, "got energy",
                              rsp_payload.energy, rsp_payload.status);
               end
            end
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   function automatic seci_pkg::req_type make_req(seci_pkg::opcode_type op, int seg,
                                                  int ph, int pe);
      seci_pkg::req_type t;
      t.opcode = op;
      t.segment = seg[7:0];
      t.height = ph[23:0];
      t.point_energy = pe;
      return t;
   endfunction

   function automatic logic [23:0] rand_height();
      case ($urandom_range(0, 3))
         0: return 24'(24'h800000 | $urandom_range(0, 15));
         1: return 24'(24'h7ffff0 | $urandom_range(0, 15));
         2: return 24'($urandom_range(0, 2000) - 1000);
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic test_directed();
      send_request(make_req(seci_pkg::OP_CONVERT, 0, 0, 0));             // empty table
      send_request(make_req(seci_pkg::OP_APPEND, NSEG, 0, 0));           // bad segment
      send_request(make_req(seci_pkg::OP_CONVERT, 255, 0, 0));
      send_request(make_req(seci_pkg::OP_NONE, 3, 5, 7));
      send_request(make_req(seci_pkg::OP_APPEND, 1, -8388608, 32'sh80000000));
      send_request(make_req(seci_pkg::OP_APPEND, 1, 8388607, 2147483647));
      send_request(make_req(seci_pkg::OP_CONVERT, 1, -8388608, 0));      // first point
      send_request(make_req(seci_pkg::OP_CONVERT, 1, 0, 0));
      send_request(make_req(seci_pkg::OP_CONVERT, 1, 8388607, 0));
      send_request(make_req(seci_pkg::OP_APPEND, 2, 100, 1000));
      send_request(make_req(seci_pkg::OP_APPEND, 2, 100, 5000));         // zero interval
      send_request(make_req(seci_pkg::OP_CONVERT, 2, 200, 0));
      send_request(make_req(seci_pkg::OP_APPEND, 3, 100, 32'sh80000000));
      send_request(make_req(seci_pkg::OP_APPEND, 3, 101, 2147483647));
      send_request(make_req(seci_pkg::OP_CONVERT, 3, 8388607, 0));       // saturate high
      send_request(make_req(seci_pkg::OP_APPEND, 4, 100, 2147483647));
      send_request(make_req(seci_pkg::OP_APPEND, 4, 50, 32'sh80000000)); // unsorted
      send_request(make_req(seci_pkg::OP_CONVERT, 4, -8388608, 0));
      for (int i = 0; i <= NPTS; i++)
         send_request(make_req(seci_pkg::OP_APPEND, 5, i * 16, i * 7));
      send_request(make_req(seci_pkg::OP_CONVERT, 5, 77, 0));
      send_request(make_req(seci_pkg::OP_CLEAR, 9, 0, 0));
      send_request(make_req(seci_pkg::OP_CONVERT, 5, 77, 0));
   endtask

   task automatic test_random();
      seci_pkg::req_type t;
      int seg, n, h;
      for (int i = 0; i < 1950; ) begin
         if ($urandom_range(0, 3) != 0) begin
            // build a table then query it
            seg = $urandom_range(0, NSEG - 1);
            n = $urandom_range(1, NPTS);
            h = $urandom_range(0, 40) - 20;
            for (int j = 0; j < n; j++) begin
               h += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 500);
               if ($urandom_range(0, 7) == 0)
                  send_request(make_req(seci_pkg::OP_APPEND, seg,
                                        int'($signed(rand_height())), $urandom()));
               else
                  send_request(make_req(seci_pkg::OP_APPEND, seg, h, $urandom()));
               i++;
            end
            repeat ($urandom_range(1, 6)) begin
               send_request(make_req(seci_pkg::OP_CONVERT, seg,
                  ($urandom_range(0, 2) == 0) ? int'($signed(rand_height()))
                                               : $urandom_range(0, h + 200) - 100, 0));
               i++;
            end
            if ($urandom_range(0, 5) == 0) begin
               send_request(make_req(seci_pkg::OP_CLEAR, $urandom(), 0, 0));
               i++;
            end
         end else begin
            t.opcode = seci_pkg::opcode_type'(2'($urandom_range(0, 3)));
            t.segment = 8'($urandom());
            t.height = rand_height();
            t.point_energy = $urandom();
            if ($urandom_range(0, 1)) t.segment = 8'($urandom_range(0, NSEG - 1));
            if (t.opcode == seci_pkg::OP_CLEAR && $urandom_range(0, 3) != 0)
               t.opcode = seci_pkg::OP_CONVERT;
            send_request(t);
            i++;
         end
         if (i % 300 == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_random();
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && energy_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
